FILE: src/ipv4_destination_blocklist_filter_defines.svh
// Assertion macros used by the blocklist filter top level.
`ifndef IPV4_DESTINATION_BLOCKLIST_FILTER_DEFINES_SVH
`define IPV4_DESTINATION_BLOCKLIST_FILTER_DEFINES_SVH
// Same-cycle implication, disabled during reset.
`define IDBF_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define IDBF_ASSERT_NXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

FILE: src/idbf_pkg.sv
// Types and constants of the IPv4 destination blocklist filter.
`timescale 1ns / 1ps
package idbf_pkg;
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [2:0] RSN_SHORT_FRAME = 3'd0;
  localparam logic [2:0] RSN_NOT_IPV4    = 3'd1;
  localparam logic [2:0] RSN_SHORT_IP    = 3'd2;
  localparam logic [2:0] RSN_NOT_LISTED  = 3'd3;
  localparam logic [2:0] RSN_LISTED      = 3'd4;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_PRESENT   = 2'd3;

  localparam logic [5:0]  HDR_LEN_ETH    = 6'd14;
  localparam logic [5:0]  HDR_LEN_IP     = 6'd34;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

  typedef enum logic [1:0] {
    OP_VERDICT,
    OP_LOOKUP,
    OP_INSERT,
    OP_REMOVE
  } op_t;

  // One operation traveling down the cell chain.
  typedef struct packed {
    logic        vld;
    op_t         op;
    logic [31:0] addr;
    logic        hit;
    logic        placed;
    logic [2:0]  reason;
  } token_t;
endpackage

FILE: src/ipv4_destination_blocklist_filter.sv
// Top level of the IPv4 destination blocklist filter.
//
// The input stream carries one item per transaction: in_tuser is the kind (frame
// byte, insert address, remove address), in_tlast marks the last frame byte, and
// in_tdata holds the frame byte and the address. Frame bytes are parsed as they
// arrive; the last byte of a frame, and every insert or remove, launches one
// operation into a chain of TABLE_DEPTH cells, each holding one blocked address.
// An operation moves one cell per cycle while the chain advances, so every result
// reaches the output stream through all TABLE_DEPTH cell registers, in input order.
// Frame bytes other than the last, and items of the unused kind, give no result.
// Throughput is one item per cycle while the receiver does not stall; the chain
// carries up to TABLE_DEPTH results in flight at once.
// The whole chain advances in lockstep; when the receiver stalls with a result
// waiting in the last cell, the chain freezes and in_tready drops with it.
// Reset (rst_n low at a clock edge) empties the table and clears the frame
// parser at once; no clearing pass is needed.
`timescale 1ns / 1ps
`include "ipv4_destination_blocklist_filter_defines.svh"
module ipv4_destination_blocklist_filter #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // [7:0] data_byte, [39:8] address
  input  logic [1:0]  in_tuser,  // [1:0] kind
  input  logic        in_tlast,  // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // [0] drop, [3:1] reason, [5:4] status, [7:6] zero
  output logic        out_tuser  // result_kind
);
  logic             advance, accept;
  idbf_pkg::token_t chain [TABLE_DEPTH+1];
  idbf_pkg::token_t tail;
  logic             drop;
  logic [2:0]       reason;
  logic [1:0]       status;

  assign advance   = !tail.vld || out_tready;
  assign in_tready = advance;
  assign accept    = in_tvalid && advance;

  idbf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .kind      (in_tuser),
    .data_byte (in_tdata[7:0]),
    .last_byte (in_tlast),
    .address   (in_tdata[39:8]),
    .token     (chain[0])
  );

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    idbf_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  assign tail = chain[TABLE_DEPTH];

  // The last cell's register doubles as the output register.
  always_comb begin
    drop   = 1'b0;
    reason = tail.reason;
    status = idbf_pkg::ST_DONE;
    case (tail.op)
      idbf_pkg::OP_LOOKUP: begin
        drop   = tail.hit;
        reason = tail.hit ? idbf_pkg::RSN_LISTED : idbf_pkg::RSN_NOT_LISTED;
      end
      idbf_pkg::OP_INSERT: begin
        reason = 3'd0;
        status = tail.hit ? idbf_pkg::ST_PRESENT
               : (tail.placed ? idbf_pkg::ST_DONE : idbf_pkg::ST_FULL);
      end
      idbf_pkg::OP_REMOVE: begin
        reason = 3'd0;
        status = tail.hit ? idbf_pkg::ST_DONE : idbf_pkg::ST_NOT_FOUND;
      end
      default: ;
    endcase
  end

  assign out_tvalid = tail.vld;
  assign out_tuser  = (tail.op == idbf_pkg::OP_INSERT) || (tail.op == idbf_pkg::OP_REMOVE);
  assign out_tdata  = {2'b00, status, reason, drop};

  `IDBF_ASSERT_IMP(a_drop_only_listed, clk, rst_n, out_tvalid && drop, !out_tuser && reason == idbf_pkg::RSN_LISTED, "drop without listed verdict")
  `IDBF_ASSERT_IMP(a_status_only_update, clk, rst_n, out_tvalid && status != idbf_pkg::ST_DONE, out_tuser, "status on frame verdict")
  `IDBF_ASSERT_IMP(a_verdict_no_hit, clk, rst_n, tail.vld && tail.op == idbf_pkg::OP_VERDICT, !tail.hit, "hit on a verdict without lookup")
  `IDBF_ASSERT_NXT(a_freeze_on_stall, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "chain moved while stalled")
endmodule

FILE: src/idbf_parser.sv
// Frame header parser that turns accepted items into chain operations.
`timescale 1ns / 1ps
module idbf_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [1:0]       kind,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic [31:0]      address,
  output idbf_pkg::token_t token
);
  logic [5:0]  pos_r, pos_nxt, p_inc;
  logic [15:0] etype_r, etype_nxt;
  logic [31:0] dest_r, dest_nxt;

  always_comb begin
    etype_nxt = etype_r;
    dest_nxt  = dest_r;
    if (pos_r == 6'd12) etype_nxt = {data_byte, etype_r[7:0]};
    else if (pos_r == 6'd13) etype_nxt = {etype_r[15:8], data_byte};
    else if (pos_r >= 6'd30 && pos_r <= 6'd33) dest_nxt = {dest_r[23:0], data_byte};
    p_inc = (pos_r < idbf_pkg::HDR_LEN_IP) ? pos_r + 6'd1 : pos_r;
    pos_nxt = last_byte ? 6'd0 : p_inc;

    token        = '0;
    token.op     = idbf_pkg::OP_VERDICT;
    token.addr   = address;
    case (kind)
      idbf_pkg::KIND_BYTE: begin
        token.vld = accept && last_byte;
        if (p_inc < idbf_pkg::HDR_LEN_ETH) token.reason = idbf_pkg::RSN_SHORT_FRAME;
        else if (etype_nxt != idbf_pkg::ETHERTYPE_IPV4) token.reason = idbf_pkg::RSN_NOT_IPV4;
        else if (p_inc < idbf_pkg::HDR_LEN_IP) token.reason = idbf_pkg::RSN_SHORT_IP;
        else begin
          token.op   = idbf_pkg::OP_LOOKUP;
          token.addr = dest_nxt;
        end
      end
      idbf_pkg::KIND_INSERT: begin
        token.vld = accept;
        token.op  = idbf_pkg::OP_INSERT;
      end
      idbf_pkg::KIND_REMOVE: begin
        token.vld = accept;
        token.op  = idbf_pkg::OP_REMOVE;
      end
      default: token.vld = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      etype_r <= '0;
      dest_r  <= '0;
    end else if (accept && kind == idbf_pkg::KIND_BYTE) begin
      pos_r   <= pos_nxt;
      etype_r <= last_byte ? 16'd0 : etype_nxt;
      dest_r  <= last_byte ? 32'd0 : dest_nxt;
    end
  end
endmodule

FILE: src/idbf_cell.sv
// One table cell: holds one blocked address and processes a passing operation.
`timescale 1ns / 1ps
module idbf_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  idbf_pkg::token_t tok_in,
  output idbf_pkg::token_t tok_out
);
  logic             valid_r, valid_nxt;
  logic [31:0]      entry_r, entry_nxt;
  idbf_pkg::token_t tok_r, tok_nxt;
  logic             match;

  assign match = valid_r && (entry_r == tok_in.addr);

  always_comb begin
    tok_nxt   = tok_in;
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (tok_in.vld) begin
      case (tok_in.op)
        idbf_pkg::OP_LOOKUP: if (match) tok_nxt.hit = 1'b1;
        idbf_pkg::OP_INSERT: begin
          if (match) begin
            tok_nxt.hit = 1'b1;
            // A copy was already placed upstream; drop this one so entries stay unique.
            if (tok_in.placed) valid_nxt = 1'b0;
          end else if (!valid_r && !tok_in.placed && !tok_in.hit) begin
            valid_nxt      = 1'b1;
            entry_nxt      = tok_in.addr;
            tok_nxt.placed = 1'b1;
          end
        end
        idbf_pkg::OP_REMOVE: if (match && !tok_in.hit) begin
          valid_nxt   = 1'b0;
          tok_nxt.hit = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Only the valid flags are reset; the payload is qualified by them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_nxt;
      entry_r <= entry_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_out = tok_r;
endmodule
